[sv/sprite_attribute_list_writer_defines.svh]
// Assertion helpers shared by the sprite attribute list writer.
`ifndef SPRITE_ATTRIBUTE_LIST_WRITER_DEFINES_SVH
`define SPRITE_ATTRIBUTE_LIST_WRITER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SALW_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define SALW_ASSERT(name, prop, msg) \
  `SALW_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

[sv/salw_pkg.sv]
package salw_pkg;

  // Default number of sprite slots in the low attribute table.
  localparam int unsigned SALW_SPRITE_SLOTS = 128;

  // Fixed field widths.
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned HIGH_BYTES = 32;
  localparam int unsigned HIGH_IDX_W = 5;

  // Restore values of the two slot indices, in bytes.
  localparam int unsigned MAIN_RESTORE   = 16;
  localparam int unsigned SHADOW_RESTORE = 272;

  // Visible window: screen X in -64..255, screen Y in -32..223.
  localparam logic [17:0] X_BIAS = 18'h00040;
  localparam logic [16:0] X_SPAN = 17'h00140;
  localparam logic [17:0] Y_BIAS = 18'h00020;

  // Shadow companion attribute forcing.
  localparam logic [7:0] SHADOW_ATTR_KEEP = 8'hF8;
  localparam logic [7:0] SHADOW_ATTR_SET  = 8'h02;

  // Masks that keep the other three 2-bit fields of a high table byte.
  localparam logic [3:0][7:0] KEEP_MASK = {8'h3F, 8'hCF, 8'hF3, 8'hFC};

  typedef enum logic {
    OP_EMIT  = 1'b0,
    OP_FRAME = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_CAMERA_X      = 2'd0,
    CFG_CAMERA_Y      = 2'd1,
    CFG_SHADOW_OFFSET = 2'd2
  } cfg_index_e;

  // Screen placement of one sprite.
  typedef struct packed {
    logic       ok;
    logic       x_hi;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } place_t;

  // Subtract the camera origin and check the visible window.
  function automatic place_t salw_place(logic [15:0] wx, logic [15:0] wy,
                                        logic [15:0] cx, logic [15:0] cy);
    logic [17:0] tx;
    logic [17:0] ty;
    logic [8:0]  sx;
    place_t      p;
    tx = {2'b00, wx} + X_BIAS - {2'b00, cx};
    ty = {2'b00, wy} + Y_BIAS - {2'b00, cy};
    sx = tx[8:0] - X_BIAS[8:0];
    p.ok     = !tx[17] && (tx[16:0] < X_SPAN) && !ty[17] && (ty[16:8] == 9'd0);
    p.x_hi   = sx[8];
    p.x_byte = sx[7:0];
    p.y_byte = ty[7:0] - Y_BIAS[7:0];
    return p;
  endfunction

endpackage

[sv/sprite_attribute_list_writer.sv]
// Sprite attribute list writer. Each emit request on the slave stream places a sprite relative
// to the camera and, when the shadow offset is nonzero, a shadow companion; every sprite that
// lands on screen yields one master-stream result with its four attribute bytes and the updated
// high table byte, main before shadow, tlast on the final one. A request that places both sprites
// takes a main step, then a shadow step, as the 32-byte high table is read-modified-written
// through a single port once per cycle while the output register accepts. A frame-start request
// yields nothing. Requests are accepted back to back while the output register drains; a stall on
// the master side holds the request in the input register.
module sprite_attribute_list_writer
  import salw_pkg::*;
#(
  parameter int unsigned SPRITE_SLOTS = SALW_SPRITE_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Sprite requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // world_x[15:0], world_y[31:16], tile_number[40:32], attribute[48:41], zero[55:49]
  input  logic [55:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  // Sprite results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot[6:0], x_byte[14:7], y_byte[22:15], tile_byte[30:23], attr_bits[38:31],
  // high_index[43:39], high_byte[51:44], zero[55:52]
  output logic [55:0] m_axis_tdata,
  // is_shadow[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  `include "sprite_attribute_list_writer_defines.svh"

  localparam int unsigned TABLE_BYTES  = SPRITE_SLOTS * 4;
  localparam int unsigned MAIN_START   = MAIN_RESTORE % TABLE_BYTES;
  localparam int unsigned SHADOW_START = SHADOW_RESTORE % TABLE_BYTES;
  localparam logic [IDX_W:0] TABLE_LIMIT = (IDX_W + 1)'(TABLE_BYTES);

  // Configuration registers.
  logic [15:0] camera_x_q, camera_y_q;
  logic [7:0]  shadow_offset_q;

  // Input register.
  logic        item_valid_q;
  logic        phase_q;
  opcode_e     item_op_q;
  logic [15:0] wx_q, wy_q;
  logic [8:0]  tile_q;
  logic [7:0]  attr_q;

  // Slot indices and high table.
  logic [IDX_W-1:0] main_index_q, shadow_index_q;
  logic [7:0]       high_tab_q [HIGH_BYTES];

  // Output register.
  logic        out_valid_q;
  logic [55:0] out_data_q;
  logic        out_shadow_q, out_last_q;

  logic             s_accept;
  logic [15:0]      shadow_x, shadow_y;
  place_t           main_pl, shadow_pl, sel_pl;
  logic             shadow_on, sel_shadow, active, out_free;
  logic             out_load, go_shadow, item_done, last_d;
  logic [IDX_W-1:0] sel_index, index_adv;
  logic [IDX_W:0]   index_sum;
  logic [7:0]       attr_used, attr_bits, new_byte;
  logic [HIGH_IDX_W-1:0] hi_index;
  logic [1:0]       lane;
  logic [1:0]       field;
  logic [55:0]      out_data_d;

  assign cfg_ready_o = 1'b1;
  assign s_accept    = s_axis_tvalid && s_axis_tready;

  // Configuration writes; the index outside the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_x_q      <= '0;
      camera_y_q      <= '0;
      shadow_offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_CAMERA_X:      camera_x_q      <= cfg_data_i;
        CFG_CAMERA_Y:      camera_y_q      <= cfg_data_i;
        CFG_SHADOW_OFFSET: shadow_offset_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Placement of the main sprite and of its shadow, both evaluated every cycle.
  assign shadow_x  = wx_q + {8'd0, shadow_offset_q};
  assign shadow_y  = wy_q + {8'd0, shadow_offset_q};
  assign main_pl   = salw_place(wx_q, wy_q, camera_x_q, camera_y_q);
  assign shadow_pl = salw_place(shadow_x, shadow_y, camera_x_q, camera_y_q);
  assign shadow_on = (shadow_offset_q != 8'd0) && shadow_pl.ok;

  // Pick the sprite handled this cycle: the main one unless it is off screen or already done.
  assign sel_shadow = phase_q || !main_pl.ok;
  assign active     = item_valid_q && (item_op_q == OP_EMIT) &&
                      (phase_q ? shadow_pl.ok : (main_pl.ok || shadow_on));
  assign out_free   = !out_valid_q || m_axis_tready;
  assign out_load   = active && out_free;
  assign go_shadow  = out_load && !sel_shadow && shadow_on;
  assign item_done  = item_valid_q && !(active && !out_free) && !go_shadow;
  assign last_d     = sel_shadow || !shadow_on;
  assign s_axis_tready = !item_valid_q || item_done;

  assign sel_pl    = sel_shadow ? shadow_pl : main_pl;
  assign sel_index = sel_shadow ? shadow_index_q : main_index_q;
  assign attr_used = sel_shadow ? ((attr_q & SHADOW_ATTR_KEEP) | SHADOW_ATTR_SET) : attr_q;
  assign attr_bits = {attr_used[6:0], tile_q[8]};

  // Read-modify-write of the 2-bit {size, X bit 8} field in the high table.
  assign hi_index = sel_index[IDX_W-1:4];
  assign lane     = sel_index[3:2];
  assign field    = {attr_used[7], sel_pl.x_hi};
  assign new_byte = (high_tab_q[hi_index] & KEEP_MASK[lane]) | (8'(field) << {lane, 1'b0});

  // Advance by one slot, wrapping at the table size.
  assign index_sum = {1'b0, sel_index} + (IDX_W + 1)'(4);
  assign index_adv = (index_sum >= TABLE_LIMIT) ? IDX_W'(index_sum - TABLE_LIMIT)
                                                : index_sum[IDX_W-1:0];

  assign out_data_d = {4'd0, new_byte, hi_index, attr_bits, tile_q[7:0],
                       sel_pl.y_byte, sel_pl.x_byte, sel_index[8:2]};

  // Input register and shadow phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      phase_q      <= 1'b0;
    end else begin
      if (s_accept) begin
        item_valid_q <= 1'b1;
      end else if (item_done) begin
        item_valid_q <= 1'b0;
      end
      if (go_shadow) begin
        phase_q <= 1'b1;
      end else if (item_done) begin
        phase_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_op_q <= opcode_e'(s_axis_tuser);
      wx_q      <= s_axis_tdata[15:0];
      wy_q      <= s_axis_tdata[31:16];
      tile_q    <= s_axis_tdata[40:32];
      attr_q    <= s_axis_tdata[48:41];
    end
  end

  // Slot indices and high table contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_index_q   <= IDX_W'(MAIN_START);
      shadow_index_q <= IDX_W'(SHADOW_START);
      for (int i = 0; i < HIGH_BYTES; i++) begin
        high_tab_q[i] <= '0;
      end
    end else begin
      if (item_valid_q && (item_op_q == OP_FRAME)) begin
        main_index_q   <= IDX_W'(MAIN_START);
        shadow_index_q <= IDX_W'(SHADOW_START);
      end else if (out_load) begin
        if (sel_shadow) begin
          shadow_index_q <= index_adv;
        end else begin
          main_index_q <= index_adv;
        end
      end
      if (out_load) begin
        high_tab_q[hi_index] <= new_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q   <= out_data_d;
      out_shadow_q <= sel_shadow;
      out_last_q   <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_shadow_q;
  assign m_axis_tlast  = out_last_q;

  // The shadow phase only exists for an emit request held in the input register.
  `SALW_ASSERT(a_phase_needs_emit, phase_q |-> item_valid_q && (item_op_q == OP_EMIT),
               "shadow phase without an emit request")
  // Slot indices stay slot-aligned and inside the table.
  `SALW_ASSERT(a_index_range,
               (main_index_q[1:0] == 2'b00) && ({1'b0, main_index_q} < TABLE_LIMIT) &&
               (shadow_index_q[1:0] == 2'b00) && ({1'b0, shadow_index_q} < TABLE_LIMIT),
               "slot index out of range")
  // A result without tlast is always followed by the shadow phase of the same request.
  `SALW_ASSERT(a_not_last_goes_shadow, out_load && !last_d |=> phase_q && item_valid_q,
               "non-final result without a pending shadow sprite")

endmodule
